/* src/ptm_pkg.sv */
package ptm_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int USED_W     = $clog2(NODE_COUNT + 1);

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [5:0] MAX_DEPTH = 6'd32;

    typedef struct packed {
        logic             mark;
        logic [IDX_W-1:0] child1;
        logic [IDX_W-1:0] child0;
    } t_node;

endpackage

/* src/ptm_node_ram.sv */
module ptm_node_ram
    import ptm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_node            o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_node            i_wr_data
);

    t_node r_mem [NODE_COUNT];
    t_node r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/ipv4_prefix_trie_match_top.sv */
// Binary trie of IPv4 prefixes, one key bit per level, held in a node memory.
// The input channel carries one operation per beat: lookup, insert or clear.
// An input beat is taken when i_in_valid is high and o_in_stall is low; the
// block then works on that operation alone and raises o_in_stall until its
// result is parked for the output side.
// Each operation gives exactly one output beat with found and status.
// Clear, the unused code and a lookup of key zero go straight to the done
// state without reading the node memory. Lookup and insert read one node per
// trie level from the node memory, at most 33 levels for a lookup; an insert
// that builds new nodes writes one link per new node and then marks the
// last one.
// The output register holds a finished result while the receiver stalls;
// the next operation can be taken meanwhile, but it cannot finish until
// that register has been emptied.
// Synchronous reset leaves a lone unmarked root and an empty output. No
// clearing pass is needed: the root reads as empty until it is written and
// every other node is written when it is allocated.
module ipv4_prefix_trie_match_top
    import ptm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_key,
    input  logic [5:0]  i_prefix_len,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_found,
    output logic [1:0]  o_status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_BLD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              r_root_valid, n_root_valid;
    logic [USED_W-1:0] r_used, n_used;

    logic [1:0]        r_op, n_op;
    logic [31:0]       r_key, n_key;
    logic [5:0]        r_plen, n_plen;
    logic [5:0]        r_depth, n_depth;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic              r_hit, n_hit;
    t_node             r_node_data, n_node_data;
    logic              r_res_found, n_res_found;
    logic [1:0]        r_res_status, n_res_status;
    logic              r_found, n_found;
    logic [1:0]        r_status, n_status;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    t_node             ram_q;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_node             wr_data;
    t_node             node_q;
    logic [IDX_W-1:0]  nxt;
    logic [IDX_W-1:0]  fresh;
    logic              hit_now;

    ptm_node_ram u_node_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    always_comb begin
        node_q  = (r_cur == '0 && !r_root_valid) ? t_node'('0) : ram_q;
        nxt     = r_key[31] ? node_q.child1 : node_q.child0;
        fresh   = r_used[IDX_W-1:0];
        hit_now = r_hit | node_q.mark;

        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_root_valid = r_root_valid;
        n_used       = r_used;
        n_op         = r_op;
        n_key        = r_key;
        n_plen       = r_plen;
        n_depth      = r_depth;
        n_cur        = r_cur;
        n_hit        = r_hit;
        n_node_data  = r_node_data;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_found      = r_found;
        n_status     = r_status;

        rd_en   = 1'b0;
        rd_addr = r_cur;
        wr_en   = 1'b0;
        wr_addr = r_cur;
        wr_data = r_node_data;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op         = i_operation;
                    n_key        = i_key;
                    n_plen       = (i_prefix_len > MAX_DEPTH) ? MAX_DEPTH : i_prefix_len;
                    n_depth      = '0;
                    n_cur        = '0;
                    n_hit        = 1'b0;
                    n_res_found  = 1'b0;
                    n_res_status = ST_OK;
                    case (i_operation)
                        OP_LOOKUP: begin
                            n_state = (i_key == '0) ? S_DONE : S_RD;
                        end
                        OP_INSERT: begin
                            n_state = S_RD;
                        end
                        OP_CLEAR: begin
                            n_root_valid = 1'b0;
                            n_used       = USED_W'(1);
                            n_state      = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_cur;
                n_state = S_EV;
            end
            S_EV: begin
                if (r_op == OP_LOOKUP) begin
                    n_hit = hit_now;
                    if (r_depth == MAX_DEPTH || nxt == '0) begin
                        n_res_found = hit_now;
                        n_state     = S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = nxt;
                        n_cur   = nxt;
                        n_key   = {r_key[30:0], 1'b0};
                        n_depth = r_depth + 6'd1;
                    end
                end else if (r_depth == r_plen) begin
                    if (node_q.mark) begin
                        n_res_status = ST_DUP;
                    end else begin
                        wr_en        = 1'b1;
                        wr_data      = node_q;
                        wr_data.mark = 1'b1;
                    end
                    n_state = S_DONE;
                end else if (nxt != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = nxt;
                    n_cur   = nxt;
                    n_key   = {r_key[30:0], 1'b0};
                    n_depth = r_depth + 6'd1;
                end else begin
                    n_node_data = node_q;
                    n_state     = S_BLD;
                end
            end
            S_BLD: begin
                wr_en = 1'b1;
                if (r_depth == r_plen) begin
                    wr_data.mark = 1'b1;
                    n_state      = S_DONE;
                end else if (r_used >= USED_W'(NODE_COUNT)) begin
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    if (r_key[31]) begin
                        wr_data.child1 = fresh;
                    end else begin
                        wr_data.child0 = fresh;
                    end
                    n_cur       = fresh;
                    n_node_data = '0;
                    n_used      = r_used + USED_W'(1);
                    n_key       = {r_key[30:0], 1'b0};
                    n_depth     = r_depth + 6'd1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_found     = r_res_found;
                    n_status    = r_res_status;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (wr_en && wr_addr == '0) begin
            n_root_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_root_valid <= 1'b0;
            r_used       <= USED_W'(1);
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_root_valid <= n_root_valid;
            r_used       <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_plen       <= n_plen;
        r_depth      <= n_depth;
        r_cur        <= n_cur;
        r_hit        <= n_hit;
        r_node_data  <= n_node_data;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        r_found      <= n_found;
        r_status     <= n_status;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_status    = r_status;

endmodule
